// ----- rtl/core/lowest_free_id_allocator_defines.svh -----
// ---------------------------------------------------------------------------
// lowest free id allocator: assertion macros
// shared property forms for the allocator checks, clocked on clk and
// disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef LOWEST_FREE_ID_ALLOCATOR_DEFINES_SVH
`define LOWEST_FREE_ID_ALLOCATOR_DEFINES_SVH

// antecedent and consequent in the same cycle
`define LFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define LFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lfa_pkg.sv -----
// ---------------------------------------------------------------------------
// lfa_pkg
// types and codes shared by the lowest free id allocator modules
// ---------------------------------------------------------------------------
package lfa_pkg;

    // used map is held as words of this many ids
    localparam int WORD_BITS = 32;
    localparam int WORD_LOG  = 5;

    // operation codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LOOK_RD,
        ST_LOOK_CHK,
        ST_FINISH
    } lfa_state_t;

    // result of the free-bit search on one map word
    typedef struct packed {
        logic                found;
        logic [WORD_LOG-1:0] pos;
    } lfa_hit_t;

endpackage

// ----- rtl/core/lowest_free_id_allocator.sv -----
// ---------------------------------------------------------------------------
// lowest_free_id_allocator
// handle table that hands out the lowest free id and maps ids to addresses
// ---------------------------------------------------------------------------
// Each request gives exactly one response. Allocate stores new_address under
// the lowest free id and returns it in given_id (status full when no id is
// free); find returns the stored address of an id in use; delete frees an id.
// An id at or above NUM_IDS, a free id and an unknown operation all answer
// not found. One request is worked on at a time: allocate scans the used map
// one 32-id word per cycle through the single read port of the map memory,
// stopping at the first word with a free id or after the last of NUM_WORDS
// words, NUM_WORDS being NUM_IDS / 32 rounded up (8 words at the default 256
// ids). After reset the used map is swept to zero, one word per cycle, with
// in_stall high. The response waits in an output register, so a finished
// response held by out_stall does not stop the next request being accepted.
// ---------------------------------------------------------------------------
`include "lowest_free_id_allocator_defines.svh"

module lowest_free_id_allocator
    import lfa_pkg::*;
#(
    parameter int NUM_IDS   = 256,
    parameter int ADDR_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  lookup_id,
    input  logic [31:0] new_address,
    // response channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  given_id,
    output logic [31:0] found_address
);

    // geometry of the used map
    localparam int NUM_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int ID_BITS   = $clog2(NUM_IDS);
    localparam int ID_EXT    = ID_BITS + WORD_LOG;
    localparam int LAST_BITS = NUM_IDS - (NUM_WORDS - 1) * WORD_BITS;

    localparam logic [WORD_AW:0]    LAST_PTR  = (WORD_AW + 1)'(NUM_WORDS - 1);
    localparam logic [WORD_AW-1:0]  LAST_IDX  = WORD_AW'(NUM_WORDS - 1);
    localparam logic [16:0]         NUM_IDS_W = 17'(NUM_IDS);
    // ids past NUM_IDS in the last word always look used
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        WORD_BITS'((64'(1) << LAST_BITS) - 64'(1));

    // sequencer state
    lfa_state_t state_reg, state_next;

    // captured request
    logic [1:0]           op_reg, op_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;

    // scan pointers; rd_ptr also walks the clearing pass
    logic [WORD_AW:0]     rd_ptr_reg, rd_ptr_next;
    logic [WORD_AW-1:0]   chk_ptr_reg, chk_ptr_next;
    logic                 pend_reg, pend_next;

    // response being built
    logic [1:0]           res_status_reg, res_status_next;
    logic [7:0]           res_id_reg, res_id_next;
    logic [31:0]          res_addr_reg, res_addr_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic [7:0]           given_id_reg, given_id_next;
    logic [31:0]          found_address_reg, found_address_next;

    // memory ports
    logic                 map_rd_en;
    logic [WORD_AW-1:0]   map_rd_addr;
    logic [WORD_BITS-1:0] map_rd_data;
    logic                 map_wr_en;
    logic [WORD_AW-1:0]   map_wr_addr;
    logic [WORD_BITS-1:0] map_wr_data;
    logic                 tab_rd_en;
    logic [ADDR_BITS-1:0] tab_rd_data;
    logic                 tab_wr_en;

    // decoded helpers
    logic                 in_take;
    logic                 out_free;
    logic                 issue;
    logic [WORD_BITS-1:0] scan_mask;
    lfa_hit_t             hit;
    logic [ID_BITS-1:0]   new_id;
    logic [ID_EXT-1:0]    id_ext;
    logic [WORD_AW-1:0]   id_word;
    logic [WORD_LOG-1:0]  id_bit;
    logic                 id_used;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // scan reads run one word ahead of the check
    assign issue     = (state_reg == ST_SCAN) && (rd_ptr_reg <= LAST_PTR);
    assign scan_mask = (chk_ptr_reg == LAST_IDX) ? LAST_MASK : '1;
    assign new_id    = ID_BITS'({chk_ptr_reg, hit.pos});

    // word and bit of the looked-up id
    assign id_ext  = ID_EXT'(id_reg);
    assign id_word = WORD_AW'(id_ext >> WORD_LOG);
    assign id_bit  = id_ext[WORD_LOG-1:0];
    assign id_used = map_rd_data[id_bit];

    lfa_first_zero u_first_zero (
        .word (map_rd_data),
        .mask (scan_mask),
        .hit  (hit)
    );

    // used map, one word of flags per entry, swept to zero after reset
    lfa_ram #(
        .DEPTH (NUM_WORDS),
        .AW    (WORD_AW),
        .DW    (WORD_BITS)
    ) u_used_map (
        .clk     (clk),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

    // address table, read under every in-range looked-up id; its data is used only for ids in use
    lfa_ram #(
        .DEPTH (NUM_IDS),
        .AW    (ID_BITS),
        .DW    (ADDR_BITS)
    ) u_addr_table (
        .clk     (clk),
        .rd_en   (tab_rd_en),
        .rd_addr (id_reg),
        .rd_data (tab_rd_data),
        .wr_en   (tab_wr_en),
        .wr_addr (new_id),
        .wr_data (addr_reg)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (rd_ptr_reg == LAST_PTR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (operation == OP_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if ((operation == OP_FIND || operation == OP_DELETE) &&
                             (17'(lookup_id) < NUM_IDS_W))
                    begin
                        state_next = ST_LOOK_RD;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && (hit.found || chk_ptr_reg == LAST_IDX))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_LOOK_RD:
            begin
                state_next = ST_LOOK_CHK;
            end
            ST_LOOK_CHK:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // memory controls
    always_comb
    begin
        map_rd_en   = 1'b0;
        map_rd_addr = rd_ptr_reg[WORD_AW-1:0];
        map_wr_en   = 1'b0;
        map_wr_addr = rd_ptr_reg[WORD_AW-1:0];
        map_wr_data = '0;
        tab_rd_en   = 1'b0;
        tab_wr_en   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                map_wr_en = 1'b1;
            end
            ST_SCAN:
            begin
                map_rd_en = issue;
                if (pend_reg && hit.found)
                begin
                    // mark the id used and store its address
                    map_wr_en   = 1'b1;
                    map_wr_addr = chk_ptr_reg;
                    map_wr_data = map_rd_data | (WORD_BITS'(1) << hit.pos);
                    tab_wr_en   = 1'b1;
                end
            end
            ST_LOOK_RD:
            begin
                map_rd_en   = 1'b1;
                map_rd_addr = id_word;
                tab_rd_en   = 1'b1;
            end
            ST_LOOK_CHK:
            begin
                if (id_used && op_reg == OP_DELETE)
                begin
                    map_wr_en   = 1'b1;
                    map_wr_addr = id_word;
                    map_wr_data = map_rd_data & ~(WORD_BITS'(1) << id_bit);
                end
            end
            default:
            begin
                map_rd_en = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        op_next            = op_reg;
        id_next            = id_reg;
        addr_next          = addr_reg;
        rd_ptr_next        = rd_ptr_reg;
        chk_ptr_next       = chk_ptr_reg;
        pend_next          = pend_reg;
        res_status_next    = res_status_reg;
        res_id_next        = res_id_reg;
        res_addr_next      = res_addr_reg;
        out_valid_next     = out_valid_reg && out_stall;
        status_next        = status_reg;
        given_id_next      = given_id_reg;
        found_address_next = found_address_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    op_next         = operation;
                    id_next         = ID_BITS'(lookup_id);
                    addr_next       = ADDR_BITS'(new_address);
                    rd_ptr_next     = '0;
                    pend_next       = 1'b0;
                    res_status_next = STAT_NOT_FOUND;
                    res_id_next     = '0;
                    res_addr_next   = '0;
                end
            end
            ST_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    chk_ptr_next = rd_ptr_reg[WORD_AW-1:0];
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                end
                if (pend_reg && hit.found)
                begin
                    res_status_next = STAT_OK;
                    res_id_next     = 8'(new_id);
                end
                else if (pend_reg && chk_ptr_reg == LAST_IDX)
                begin
                    res_status_next = STAT_FULL;
                end
            end
            ST_LOOK_CHK:
            begin
                if (id_used)
                begin
                    res_status_next = STAT_OK;
                    if (op_reg == OP_FIND)
                    begin
                        res_addr_next = 32'(tab_rd_data);
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = res_status_reg;
                    given_id_next      = res_id_reg;
                    found_address_next = res_addr_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rd_ptr_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        id_reg            <= id_next;
        addr_reg          <= addr_next;
        chk_ptr_reg       <= chk_ptr_next;
        res_status_reg    <= res_status_next;
        res_id_reg        <= res_id_next;
        res_addr_reg      <= res_addr_next;
        status_reg        <= status_next;
        given_id_reg      <= given_id_next;
        found_address_reg <= found_address_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign given_id      = given_id_reg;
    assign found_address = found_address_reg;

    // checks
    `LFA_ASSERT_SAME(a_clear_blocks_requests, state_reg == ST_CLEAR, in_stall,
        "request accepted during the clearing pass")
    `LFA_ASSERT_SAME(a_check_in_range, state_reg == ST_SCAN && pend_reg,
        chk_ptr_reg <= LAST_IDX, "scan check beyond the last map word")
    `LFA_ASSERT_NEXT(a_response_from_finish,
        state_reg != ST_FINISH && !(out_valid_reg && out_stall), !out_valid_reg,
        "response raised outside the finish step")
    `LFA_ASSERT_SAME(a_full_is_empty, out_valid_reg && status_reg == STAT_FULL,
        given_id_reg == 8'd0 && found_address_reg == 32'd0,
        "full response carries a non-zero id or address")

endmodule

// ----- rtl/core/lfa_ram.sv -----
// ---------------------------------------------------------------------------
// lfa_ram
// single write port, single read port memory with registered read data
// ---------------------------------------------------------------------------
module lfa_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lfa_first_zero.sv -----
// ---------------------------------------------------------------------------
// lfa_first_zero
// finds the lowest free id within one word of the used map
// ---------------------------------------------------------------------------
module lfa_first_zero
    import lfa_pkg::*;
(
    input  logic [WORD_BITS-1:0] word,
    input  logic [WORD_BITS-1:0] mask,
    output lfa_hit_t             hit
);

    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] lowest;

    // isolate the lowest set bit of the free vector
    assign free_bits = ~word & mask;
    assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

    // one-hot to index
    always_comb
    begin
        hit.found = |free_bits;
        hit.pos   = '0;
        for (int k = 0; k < WORD_LOG; k++)
        begin
            for (int b = 0; b < WORD_BITS; b++)
            begin
                if (((b >> k) & 1) == 1)
                begin
                    hit.pos[k] = hit.pos[k] | lowest[b];
                end
            end
        end
    end

endmodule
